>>> src/note_envelope_motor_drive_macros.svh
// assertion macros for the note envelope motor drive checker
`ifndef NOTE_ENVELOPE_MOTOR_DRIVE_MACROS_SVH
`define NOTE_ENVELOPE_MOTOR_DRIVE_MACROS_SVH

// clocked check, off while reset is high
`define NEMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also covers reset cycles
`define NEMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/nemd_pkg.sv
// shared constants and types for the note envelope motor drive
`default_nettype none

package nemd_pkg;

  localparam logic [1:0]  REG_ATTACK = 2'd0;
  localparam logic [1:0]  REG_RISE   = 2'd1;
  localparam logic [1:0]  REG_FALL   = 2'd2;

  localparam logic [15:0] ATTACK_RESET = 16'd5243;
  localparam logic [8:0]  RISE_RESET   = 9'd179;
  localparam logic [8:0]  FALL_RESET   = 9'd72;

  localparam logic        ACT_OFF = 1'b1;

  localparam logic [11:0] REST_BELOW = 12'd20;
  localparam logic [11:0] PITCH_LOW  = 12'd110;
  localparam logic [11:0] PITCH_HIGH = 12'd850;
  localparam logic [16:0] PITCH_SPAN = 17'd740;
  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [16:0] BASE_Q16   = 17'd42598;
  localparam logic [14:0] DEPTH_Q16  = 15'd22938;
  localparam logic [15:0] DUR_MAX    = 16'hFFFF;

  typedef struct packed {
    logic        start;
    logic [16:0] rem_init;
    logic [15:0] num_lo;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> src/nemd_div.sv
// bit-serial restoring divider, sixteen quotient bits, one per cycle
`default_nettype none

module nemd_div (
  input  logic               clk,
  input  logic               rst,
  input  nemd_pkg::div_req_t req,
  output nemd_pkg::div_rsp_t rsp
);
  import nemd_pkg::*;

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [16:0] rem;
  logic [15:0] num;
  logic [16:0] dvsr;
  logic [15:0] quot;
  logic [17:0] trial;
  logic [17:0] diff;
  logic        fits;

  always_comb begin
    trial = {rem, num[15]};
    diff  = trial - {1'b0, dvsr};
    fits  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 4'd15;
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      num  <= req.num_lo;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? diff[16:0] : trial[16:0];
      num  <= {num[14:0], 1'b0};
      quot <= {quot[14:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

>>> src/note_envelope_motor_drive.sv
// note envelope motor drive: top level with sequencer, datapath and register port
//
// input stream: one beat per update tick, s_tuser is the action (1 forces the motor
// off), s_tdata carries enable, playing flag, note frequency, length, elapsed time
// and tempo. output stream: one beat per input beat with the 8-bit pwm duty.
// one item is worked on at a time. the effective length, the phase, the envelope
// and the pitch each take one pass of a shared bit-serial divider (16 quotient
// bits each). off, disabled, rest and not-playing beats skip the divider; a
// saturated length, full phase or out-of-range pitch skips that one division.
// a finished result waits in the output register; a new beat is accepted meanwhile
// and runs until its own result is ready, then waits there for m_tready.
// reset clears the level to zero, empties the output register and loads the
// register defaults. the user must write registers through the apb port only
// while idle; the block itself does not enforce it.
`default_nettype none

module note_envelope_motor_drive (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // motor_enable, is_playing, note_freq, note_length, elapsed_time, tempo
  input  logic [63:0] s_tdata,
  // action
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pwm_duty
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nemd_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DUR   = 12'b000000000010,
    S_PHASE = 12'b000000000100,
    S_ENV   = 12'b000000001000,
    S_EDIV  = 12'b000000010000,
    S_PITCH = 12'b000000100000,
    S_STREN = 12'b000001000000,
    S_PROD  = 12'b000010000000,
    S_TGT   = 12'b000100000000,
    S_DIFF  = 12'b001000000000,
    S_APPLY = 12'b010000000000,
    S_HOLD  = 12'b100000000000
  } state_t;

  state_t      state;
  logic        div_wait;
  logic        kill;
  logic        rise_dir;

  logic [15:0] attack_fraction;
  logic [8:0]  rise_gain;
  logic [8:0]  fall_gain;
  logic [15:0] level;

  logic [11:0] note_freq;
  logic [15:0] note_length;
  logic [15:0] elapsed_time;
  logic [11:0] tempo;

  logic [15:0] dur;
  logic [16:0] phase;
  logic [16:0] env;
  logic [16:0] pitch;
  logic [16:0] strength;
  logic [31:0] dmul;
  logic [33:0] prod;
  logic [15:0] target;
  logic [16:0] delta;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        dur_sat;
  logic        phase_full;
  logic        in_attack;
  logic        pitch_low;
  logic        pitch_high;
  logic        out_free;
  logic        cfg_wr;
  logic [31:0] dmul_val;
  logic [31:0] pmul_val;
  logic [33:0] prod_val;
  logic [41:0] scaled;
  logic        rising;
  logic [15:0] mag;
  logic [8:0]  gain;
  logic [24:0] dprod;
  logic [17:0] sum;
  logic [15:0] lvl_raw;
  logic [15:0] lvl_next;

  nemd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (paddr[3:2])
      REG_ATTACK: prdata = {16'd0, attack_fraction};
      REG_RISE:   prdata = {23'd0, rise_gain};
      REG_FALL:   prdata = {23'd0, fall_gain};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_fraction <= ATTACK_RESET;
      rise_gain       <= RISE_RESET;
      fall_gain       <= FALL_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ATTACK: attack_fraction <= pwdata[15:0];
        REG_RISE:   rise_gain       <= pwdata[8:0];
        REG_FALL:   fall_gain       <= pwdata[8:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    dur_sat    = (note_length[15:8] >= tempo);
    phase_full = (elapsed_time >= dur);
    in_attack  = (attack_fraction != 16'd0) && (phase < {1'b0, attack_fraction});
    pitch_low  = (note_freq <= PITCH_LOW);
    pitch_high = (note_freq >= PITCH_HIGH);
    dmul_val   = {15'd0, phase - {1'b0, attack_fraction}} * {17'd0, DEPTH_Q16};
    pmul_val   = {15'd0, pitch} * {17'd0, DEPTH_Q16};
    prod_val   = {17'd0, env} * {17'd0, strength};
    scaled     = {prod, 8'd0} - {8'd0, prod};
    rising     = (target > level);
    mag        = rising ? (target - level) : (level - target);
    gain       = rising ? rise_gain : fall_gain;
    dprod      = {9'd0, mag} * {16'd0, gain};
    sum        = {2'd0, level} + {1'b0, delta};
    if (kill) begin
      lvl_raw = 16'd0;
    end else if (rise_dir) begin
      lvl_raw = (sum > {2'd0, DUR_MAX}) ? DUR_MAX : sum[15:0];
    end else begin
      lvl_raw = (delta >= {1'b0, level}) ? 16'd0 : (level - delta[15:0]);
    end
    lvl_next = (lvl_raw[15:8] == 8'd0) ? 16'd0 : lvl_raw;
  end

  always_comb begin
    dreq = '0;
    case (state)
      S_DUR: begin
        dreq.start    = !div_wait && !dur_sat;
        dreq.rem_init = {9'd0, note_length[15:8]};
        dreq.num_lo   = {note_length[7:0], 8'd0};
        dreq.divisor  = {5'd0, tempo};
      end
      S_PHASE: begin
        dreq.start    = !div_wait && !phase_full;
        dreq.rem_init = {1'b0, elapsed_time};
        dreq.num_lo   = 16'd0;
        dreq.divisor  = {1'b0, dur};
      end
      S_ENV: begin
        dreq.start    = !div_wait && in_attack;
        dreq.rem_init = phase;
        dreq.num_lo   = 16'd0;
        dreq.divisor  = {1'b0, attack_fraction};
      end
      S_EDIV: begin
        dreq.start    = !div_wait;
        dreq.rem_init = {1'b0, dmul[31:16]};
        dreq.num_lo   = dmul[15:0];
        dreq.divisor  = ONE_Q16 - {1'b0, attack_fraction};
      end
      S_PITCH: begin
        dreq.start    = !div_wait && !pitch_low && !pitch_high;
        dreq.rem_init = {5'd0, note_freq - PITCH_LOW};
        dreq.num_lo   = 16'd0;
        dreq.divisor  = PITCH_SPAN;
      end
      default: dreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      div_wait <= 1'b0;
      kill     <= 1'b0;
      level    <= 16'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_HOLD && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (dreq.start) begin
        div_wait <= 1'b1;
      end else if (drsp.done) begin
        div_wait <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == ACT_OFF || !s_tdata[0]) begin
              kill  <= 1'b1;
              state <= S_APPLY;
            end else begin
              kill <= 1'b0;
              if (!s_tdata[1] || s_tdata[13:2] < REST_BELOW || s_tdata[57:46] == 12'd0) begin
                state <= S_DIFF;
              end else begin
                state <= S_DUR;
              end
            end
          end
        end
        S_DUR: begin
          if (!div_wait && dur_sat) begin
            state <= S_PHASE;
          end else if (drsp.done) begin
            state <= (drsp.quot == 16'd0) ? S_DIFF : S_PHASE;
          end
        end
        S_PHASE: begin
          if ((!div_wait && phase_full) || drsp.done) begin
            state <= S_ENV;
          end
        end
        S_ENV: begin
          if (!div_wait && !in_attack) begin
            state <= S_EDIV;
          end else if (drsp.done) begin
            state <= S_PITCH;
          end
        end
        S_EDIV: begin
          if (drsp.done) begin
            state <= S_PITCH;
          end
        end
        S_PITCH: begin
          if ((!div_wait && (pitch_low || pitch_high)) || drsp.done) begin
            state <= S_STREN;
          end
        end
        S_STREN: state <= S_PROD;
        S_PROD:  state <= S_TGT;
        S_TGT:   state <= S_DIFF;
        S_DIFF:  state <= S_APPLY;
        S_APPLY: state <= S_HOLD;
        S_HOLD: begin
          if (out_free) begin
            level <= lvl_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        note_freq    <= s_tdata[13:2];
        note_length  <= s_tdata[29:14];
        elapsed_time <= s_tdata[45:30];
        tempo        <= s_tdata[57:46];
        target       <= 16'd0;
      end
      S_DUR: begin
        if (!div_wait && dur_sat) begin
          dur <= DUR_MAX;
        end else if (drsp.done) begin
          dur <= drsp.quot;
        end
      end
      S_PHASE: begin
        if (!div_wait && phase_full) begin
          phase <= ONE_Q16;
        end else if (drsp.done) begin
          phase <= {1'b0, drsp.quot};
        end
      end
      S_ENV: begin
        if (!div_wait && !in_attack) begin
          dmul <= dmul_val;
        end else if (drsp.done) begin
          env <= {1'b0, drsp.quot};
        end
      end
      S_EDIV: begin
        if (drsp.done) begin
          env <= ONE_Q16 - {1'b0, drsp.quot};
        end
      end
      S_PITCH: begin
        if (!div_wait && pitch_low) begin
          pitch <= 17'd0;
        end else if (!div_wait && pitch_high) begin
          pitch <= ONE_Q16;
        end else if (drsp.done) begin
          pitch <= {1'b0, drsp.quot};
        end
      end
      S_STREN: strength <= BASE_Q16 + {1'b0, pmul_val[31:16]};
      S_PROD:  prod <= prod_val;
      S_TGT:   target <= scaled[39:24];
      S_DIFF: begin
        rise_dir <= rising;
        delta    <= dprod[24:8];
      end
      S_HOLD: begin
        if (out_free) begin
          m_tdata <= lvl_next[15:8];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/nemd_chk.sv
// port-level checker for the note envelope motor drive, bound to the top level
`default_nettype none
`include "note_envelope_motor_drive_macros.svh"

module nemd_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // empty output register and ready for a beat right after reset
  `NEMD_ASSERT_ALWAYS(a_reset_idle, (rst |=> !m_tvalid && s_tready), "not idle after reset")

  // a stalled result beat holds
  `NEMD_ASSERT(a_out_hold, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "out beat changed")

  // one item at a time: busy right after an accepted beat
  `NEMD_ASSERT(a_one_item, (s_tvalid && s_tready |=> !s_tready), "accepted two beats in a row")

  // a new result only comes out of a busy block
  `NEMD_ASSERT(a_result_busy, ($rose(m_tvalid) |-> !$past(s_tready)), "result without work")

endmodule

bind note_envelope_motor_drive nemd_chk u_nemd_chk (.*);

`default_nettype wire

>>> bench/note_envelope_motor_drive_tb.sv
// note_envelope_motor_drive testbench: directed table, then random notes per register setting
module note_envelope_motor_drive_tb;
  import nemd_pkg::*;

  localparam int TEMPO_FRAC      = 8;
  localparam int FULL_SCALE      = 255;
  localparam int SNAP_Q88        = 256;
  localparam int PHASES          = 8;
  localparam int TICKS_PER_PHASE = 130;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 100;

  typedef struct packed {
    logic        action;
    logic        enable;
    logic        playing;
    logic [11:0] freq;
    logic [15:0] len;
    logic [15:0] elapsed;
    logic [11:0] tempo;
  } tick_t;

  typedef struct packed {
    tick_t      tick;
    logic       fixed;
    logic [7:0] duty;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // motor_enable, is_playing, note_freq, note_length, elapsed_time, tempo
  logic [63:0] s_tdata;
  // action
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // pwm_duty
  logic [7:0]  m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] attack_q16;
  logic [8:0]  rise_q8;
  logic [8:0]  fall_q8;
  logic [15:0] level_q88;
  logic [7:0]  duty_expected [$];
  row_t        directed [$];

  logic [15:0] cfg_attack [PHASES];
  logic [8:0]  cfg_rise [PHASES];
  logic [8:0]  cfg_fall [PHASES];

  int unsigned note_freq, note_len, note_tempo, note_elapsed;
  int unsigned errors, ticks_sent, beats_checked, holdoffs, stuck_cycles;
  bit          stall_req, no_gaps;

  note_envelope_motor_drive dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  task automatic log_mismatch(input string what, input int unsigned want,
                              input int unsigned got);
    errors++;
    if (errors <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  function automatic longint unsigned envelope_target(input tick_t t);
    longint unsigned att, dur, phase, env, pitch, strength;
    att = 64'(attack_q16);
    if (t.freq < REST_BELOW || t.tempo == 12'd0) return 0;
    dur = (64'(t.len) << TEMPO_FRAC) / 64'(t.tempo);
    if (dur > 64'(DUR_MAX)) dur = 64'(DUR_MAX);
    if (dur == 0) return 0;
    phase = (64'(t.elapsed) * 64'(ONE_Q16)) / dur;
    if (phase > 64'(ONE_Q16)) phase = 64'(ONE_Q16);
    if (att != 0 && phase < att)
      env = (phase * 64'(ONE_Q16)) / att;
    else
      env = 64'(ONE_Q16) - ((phase - att) * 64'(DEPTH_Q16)) / (64'(ONE_Q16) - att);
    if (t.freq <= PITCH_LOW)
      pitch = 0;
    else if (t.freq >= PITCH_HIGH)
      pitch = 64'(ONE_Q16);
    else
      pitch = ((64'(t.freq) - 64'(PITCH_LOW)) * 64'(ONE_Q16)) / 64'(PITCH_SPAN);
    strength = 64'(BASE_Q16) + ((pitch * 64'(DEPTH_Q16)) >> 16);
    return (env * strength * 64'(FULL_SCALE)) >> 24;
  endfunction

  // smoothed q8.8 level update, returns the integer duty
  function automatic logic [7:0] advance_duty(input tick_t t);
    longint unsigned target, lvl, diff, nxt;
    lvl = 64'(level_q88);
    target = 0;
    if (t.action == ACT_OFF || !t.enable) begin
      level_q88 = 16'd0;
      return 8'd0;
    end
    if (t.playing) target = envelope_target(t);
    if (target > lvl) begin
      diff = ((target - lvl) * 64'(rise_q8)) >> 8;
      nxt = lvl + diff;
      if (nxt > 64'hFFFF) nxt = 64'hFFFF;
    end else begin
      diff = ((lvl - target) * 64'(fall_q8)) >> 8;
      nxt = (diff >= lvl) ? 0 : lvl - diff;
    end
    if (nxt < 64'(SNAP_Q88)) nxt = 0;
    level_q88 = 16'(nxt);
    return 8'(nxt >> 8);
  endfunction

  function automatic void add_row(input logic a, input logic en, input logic pl,
                                  input logic [11:0] f, input logic [15:0] l,
                                  input logic [15:0] e, input logic [11:0] tp,
                                  input logic fx, input logic [7:0] d);
    row_t r;
    r.tick = '{action: a, enable: en, playing: pl, freq: f, len: l, elapsed: e, tempo: tp};
    r.fixed = fx;
    r.duty = d;
    directed.push_back(r);
  endfunction

  // mostly well-formed notes walked through their length, some noise and overrides
  function automatic tick_t roll_tick();
    tick_t t;
    int unsigned r, eff, el;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      t = 59'({$urandom, $urandom});
    end else begin
      if (r < 27 || note_len == 0) begin
        note_freq = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 19)
                                                : $urandom_range(20, 1500);
        note_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(1, 3000);
        note_tempo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(26, 2048);
        note_elapsed = 0;
      end else begin
        eff = (note_tempo == 0) ? note_len : (note_len << TEMPO_FRAC) / note_tempo;
        el = note_elapsed + $urandom_range(0, eff / 4 + 1);
        note_elapsed = (el > 65535) ? 65535 : el;
      end
      t.action = 1'b0;
      t.enable = 1'b1;
      t.playing = ($urandom_range(0, 19) != 0);
      t.freq = 12'(note_freq);
      t.len = 16'(note_len);
      t.elapsed = 16'(note_elapsed);
      t.tempo = 12'(note_tempo);
      if (r < 15)
        t.action = ACT_OFF;
      else if (r < 18)
        t.enable = 1'b0;
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input int unsigned gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.action;
    s_tdata  <= {6'd0, t.tempo, t.elapsed, t.len, t.freq, t.playing, t.enable};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    ticks_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (duty_expected.size() != 0);
  endtask

  // psel stays high across back-to-back transfers, check_regs drops it
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    case (idx)
      REG_ATTACK: attack_q16 = val[15:0];
      REG_RISE:   rise_q8 = val[8:0];
      REG_FALL:   fall_q8 = val[8:0];
      default: ;
    endcase
  endtask

  task automatic apb_check(input logic [1:0] idx);
    logic [31:0] want, got;
    case (idx)
      REG_ATTACK: want = {16'd0, attack_q16};
      REG_RISE:   want = {23'd0, rise_q8};
      default:    want = {23'd0, fall_q8};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    got = prdata;
    @(posedge clk);
    if (got !== want) log_mismatch("register readback", want, got);
  endtask

  task automatic check_regs();
    apb_check(REG_ATTACK);
    apb_check(REG_RISE);
    apb_check(REG_FALL);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : sink
    int unsigned wait_cycles;
    logic [7:0] got;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        holdoffs++;
        wait_cycles = HOLDOFF_CYCLES;
      end else begin
        wait_cycles = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      got = m_tdata;
      @(posedge clk);
      if (duty_expected.size() == 0) begin
        log_mismatch("duty beat with nothing pending", 0, got);
      end else begin
        beats_checked++;
        if (got !== duty_expected[0]) log_mismatch("pwm_duty", duty_expected[0], got);
        void'(duty_expected.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("no beat for %0d cycles, %0d results pending", stuck_cycles,
               duty_expected.size());
      $display("note_envelope_motor_drive regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    tick_t      t;
    logic [7:0] pred;
    int         p, i;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    attack_q16 = ATTACK_RESET;
    rise_q8 = RISE_RESET;
    fall_q8 = FALL_RESET;
    level_q88 = 16'd0;

    // off, disabled, rests, not playing, zero tempo and zero length from a zero level
    add_row(ACT_OFF, 1, 1, 12'hFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 1, 8'd0);
    add_row(ACT_OFF, 0, 0, 12'd440, 16'd1000, 16'd0, 12'd256, 1, 8'd0);
    add_row(1'b0, 0, 1, 12'hFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 1, 8'd0);
    add_row(1'b0, 1, 1, 12'd0, 16'd1000, 16'd0, 12'd256, 1, 8'd0);
    add_row(1'b0, 1, 1, 12'd19, 16'd1000, 16'd10, 12'd256, 1, 8'd0);
    add_row(1'b0, 1, 1, 12'd440, 16'd1000, 16'd10, 12'd0, 1, 8'd0);
    add_row(1'b0, 1, 1, 12'd440, 16'd0, 16'd10, 12'd256, 1, 8'd0);
    add_row(1'b0, 1, 0, 12'd440, 16'd1000, 16'd10, 12'd256, 1, 8'd0);
    // pitch edges, length saturation, phase clamp
    add_row(1'b0, 1, 1, 12'd20, 16'd500, 16'd20, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd110, 16'd500, 16'd40, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd850, 16'd500, 16'd100, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'hFFF, 16'hFFFF, 16'hFFFF, 12'd26, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'hFFF, 16'd1, 16'hFFFF, 12'hFFF, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'hFFF, 16'd1000, 16'hFFFF, 12'd256, 0, 8'd0);
    // one note through attack and decay, then release, rest, disabled, tempo change and zeros
    add_row(1'b0, 1, 1, 12'd440, 16'd1000, 16'd0, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd440, 16'd1000, 16'd40, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd440, 16'd1000, 16'd80, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd440, 16'd1000, 16'd500, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd440, 16'd1000, 16'd1000, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 0, 12'd440, 16'd1000, 16'd1000, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 0, 12'd440, 16'd1000, 16'd1000, 12'd256, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd0, 16'd1000, 16'd1000, 12'd256, 0, 8'd0);
    add_row(1'b0, 0, 1, 12'd440, 16'd1000, 16'd80, 12'd256, 1, 8'd0);
    add_row(1'b0, 1, 1, 12'd440, 16'd1000, 16'd80, 12'd2048, 0, 8'd0);
    add_row(1'b0, 1, 1, 12'd0, 16'd0, 16'd0, 12'd0, 0, 8'd0);

    cfg_attack[0] = ATTACK_RESET; cfg_rise[0] = RISE_RESET; cfg_fall[0] = FALL_RESET;
    cfg_attack[1] = 16'd0;        cfg_rise[1] = 9'd256;     cfg_fall[1] = 9'd256;
    cfg_attack[2] = 16'hFFFF;     cfg_rise[2] = 9'd256;     cfg_fall[2] = 9'd0;
    cfg_attack[3] = 16'd1;        cfg_rise[3] = 9'h1FF;     cfg_fall[3] = 9'h1FF;
    cfg_attack[4] = 16'h8000;     cfg_rise[4] = 9'd0;       cfg_fall[4] = 9'd300;
    for (p = 5; p < PHASES; p++) begin
      cfg_attack[p] = 16'($urandom_range(1, 65535));
      cfg_rise[p] = 9'($urandom_range(0, 256));
      cfg_fall[p] = 9'($urandom_range(0, 256));
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_regs();

    foreach (directed[k]) begin
      send_tick(directed[k].tick, $urandom_range(0, 9));
      pred = advance_duty(directed[k].tick);
      duty_expected.push_back(directed[k].fixed ? directed[k].duty : pred);
    end

    for (p = 0; p < PHASES; p++) begin
      drain_results();
      apb_write(REG_ATTACK, {16'd0, cfg_attack[p]});
      apb_write(REG_RISE, {23'd0, cfg_rise[p]});
      apb_write(REG_FALL, {23'd0, cfg_fall[p]});
      check_regs();
      no_gaps = (p == 2 || p == 5);
      for (i = 0; i < TICKS_PER_PHASE; i++) begin
        if (p == 0 && i == 40) stall_req = 1'b1;
        if (p == 1 && i == 60) drain_results();
        t = roll_tick();
        send_tick(t, no_gaps ? 0 : $urandom_range(0, 9));
        duty_expected.push_back(advance_duty(t));
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d ticks (%0d directed) over %0d register settings, %0d duty beats compared",
             ticks_sent, directed.size(), PHASES, beats_checked);
    $display("included off, disabled, rest and zero-tempo ticks, gain overshoot, %0d long stall(s)",
             holdoffs);
    if (errors == 0 && duty_expected.size() == 0)
      $display("note_envelope_motor_drive regression: pass");
    else
      $display("note_envelope_motor_drive regression: fail");
    $finish;
  end

endmodule
